// File: sv/sxsq_pkg.sv
// Shared types, constants and codes of the sixteen-step note sequencer.
package sxsq_pkg;

    localparam int STEP_COUNT = 16;
    localparam int STEP_W     = $clog2(STEP_COUNT);
    localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(STEP_COUNT - 1);

    localparam int NOTE_W  = 7;
    localparam int NVAL_W  = 10;
    localparam int TICK_W  = 14;
    localparam int GATE_W  = 8;
    localparam int BPM_W   = 9;
    localparam int FUNC_W  = 3;
    localparam int WIDX_W  = 2;

    localparam logic [NOTE_W-1:0] NOTE_MAX = NOTE_W'(127);
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
    localparam logic [GATE_W-1:0] GATE_MAX = {GATE_W{1'b1}};

    // Step period = ((PERIOD_NUM / bpm) * PERIOD_SCALE) / PERIOD_DIV
    localparam int PERIOD_NUM   = 600;
    localparam int PERIOD_SCALE = 100;
    localparam int PERIOD_DIV   = 4;
    localparam int BPM_MAX      = 360;
    localparam int BPM_RESET    = 120;

    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK  = 3'd0,
        FN_SSTOP = 3'd1,
        FN_FWD   = 3'd2,
        FN_BACK  = 3'd3,
        FN_WRITE = 3'd4,
        FN_MOVE  = 3'd5
    } func_t;

    typedef enum logic [WIDX_W-1:0] {
        REG_TEMPO  = 2'd0,
        REG_BOUNCE = 2'd1,
        REG_GATE   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] period;
        logic              bounce;
        logic [GATE_W-1:0] gate_ticks;
    } cfg_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [NVAL_W-1:0] note_value;
        logic              move_back;
    } item_t;

    typedef struct packed {
        logic [NOTE_W-1:0] tone_value;
        logic              tone_write;
        logic [STEP_W-1:0] step_index;
        logic              running;
    } result_t;

endpackage

// File: sv/sxsq_cfg.sv
// Configuration registers; the step period is derived from the tempo on write.
module sxsq_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [sxsq_pkg::WIDX_W-1:0] wr_index,
    input  logic [sxsq_pkg::BPM_W-1:0]  wr_data,
    output sxsq_pkg::cfg_t              cfg
);
    import sxsq_pkg::*;

    localparam int LUT_TOP  = PERIOD_NUM / 3;   // tempos up to here go through the table
    localparam int HALF_BPM = PERIOD_NUM / 2;   // quotient 2 up to here, 1 above
    localparam int LUT_W    = $clog2(LUT_TOP + 1);
    localparam logic [TICK_W-1:0] PER_TWO   = TICK_W'((2 * PERIOD_SCALE) / PERIOD_DIV);
    localparam logic [TICK_W-1:0] PER_ONE   = TICK_W'(PERIOD_SCALE / PERIOD_DIV);
    localparam logic [TICK_W-1:0] PER_RESET =
        TICK_W'(((PERIOD_NUM / BPM_RESET) * PERIOD_SCALE) / PERIOD_DIV);

    logic [TICK_W-1:0] period_lut [0:LUT_TOP];
    logic [TICK_W-1:0] period_next;
    cfg_t              cfg_reg;

    // Tempo zero is taken as one beat per minute.
    assign period_lut[0] = TICK_W'((PERIOD_NUM * PERIOD_SCALE) / PERIOD_DIV);

    for (genvar Bpm = 1; Bpm <= LUT_TOP; Bpm++) begin : g_lut
        localparam logic [TICK_W-1:0] Per =
            TICK_W'(((PERIOD_NUM / Bpm) * PERIOD_SCALE) / PERIOD_DIV);
        assign period_lut[Bpm] = Per;
    end

    // Anything above the half point, including tempos beyond the maximum, gets quotient 1.
    always_comb
    begin
        if (wr_data > BPM_W'(HALF_BPM))
            period_next = PER_ONE;
        else if (wr_data > BPM_W'(LUT_TOP))
            period_next = PER_TWO;
        else
            period_next = period_lut[wr_data[LUT_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period     <= PER_RESET;
            cfg_reg.bounce     <= 1'b0;
            cfg_reg.gate_ticks <= GATE_W'(10);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_TEMPO:  cfg_reg.period     <= period_next;
                REG_BOUNCE: cfg_reg.bounce     <= wr_data[0];
                REG_GATE:   cfg_reg.gate_ticks <= wr_data[GATE_W-1:0];
                default:    ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// File: sv/sxsq_core.sv
// Sequencer state and the per-word update of step, gate, tone and note table.
module sxsq_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  sxsq_pkg::cfg_t    cfg,
    input  sxsq_pkg::item_t   item,
    output sxsq_pkg::result_t res
);
    import sxsq_pkg::*;

    logic [NOTE_W-1:0] note_reg [STEP_COUNT];
    logic [STEP_W-1:0] step_reg,  step_next;
    logic              bdown_reg, bdown_next;
    logic              run_reg,   run_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic [GATE_W-1:0] gate_reg,  gate_next;
    logic [STEP_W-1:0] prev_reg,  prev_next;
    logic [NOTE_W-1:0] tone_reg,  tone_next;
    logic              wrote;
    logic              note_we;
    logic [NOTE_W-1:0] note_wdata;
    logic [STEP_W-1:0] rd_idx;
    logic [NOTE_W-1:0] rd_note;
    logic [STEP_W-1:0] step_fwd, step_bwd, step_adv;
    logic              bdown_adv;
    logic [TICK_W-1:0] ticks_inc;
    logic [GATE_W-1:0] gate_inc;
    logic              expired;

    assign step_fwd  = (step_reg == STEP_TOP) ? '0 : step_reg + 1'b1;
    assign step_bwd  = (step_reg == '0) ? STEP_TOP : step_reg - 1'b1;
    assign ticks_inc = (ticks_reg == TICK_MAX) ? ticks_reg : ticks_reg + 1'b1;
    assign gate_inc  = (gate_reg == GATE_MAX) ? gate_reg : gate_reg + 1'b1;
    assign expired   = (gate_reg >= cfg.gate_ticks);
    assign rd_note   = note_reg[rd_idx];

    // Auto-advance: loop wraps, bounce turns around at either end.
    always_comb
    begin
        step_adv  = step_reg;
        bdown_adv = bdown_reg;
        if (ticks_inc > cfg.period)
        begin
            if (!cfg.bounce)
                step_adv = step_fwd;
            else if (!bdown_reg)
            begin
                if (step_reg == STEP_TOP)
                begin
                    step_adv  = STEP_TOP - 1'b1;
                    bdown_adv = 1'b1;
                end
                else
                    step_adv = step_reg + 1'b1;
            end
            else
            begin
                if (step_reg == '0)
                begin
                    step_adv  = STEP_W'(1);
                    bdown_adv = 1'b0;
                end
                else
                    step_adv = step_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        step_next  = step_reg;
        bdown_next = bdown_reg;
        run_next   = run_reg;
        ticks_next = ticks_reg;
        gate_next  = gate_reg;
        prev_next  = prev_reg;
        tone_next  = tone_reg;
        wrote      = 1'b0;
        note_we    = 1'b0;
        note_wdata = (item.note_value > NVAL_W'(NOTE_MAX)) ? NOTE_MAX
                                                            : item.note_value[NOTE_W-1:0];
        rd_idx     = step_reg;
        case (item.func)
            FN_TICK:
            begin
                ticks_next = ticks_inc;
                if (run_reg)
                begin
                    if (ticks_inc > cfg.period)
                        ticks_next = '0;
                    step_next  = step_adv;
                    bdown_next = bdown_adv;
                    prev_next  = step_adv;
                    rd_idx     = step_adv;
                    if (prev_reg != step_adv)
                    begin
                        gate_next = '0;
                        tone_next = rd_note;
                        wrote     = 1'b1;
                    end
                    else
                    begin
                        gate_next = gate_inc;
                        if (expired)
                        begin
                            tone_next = '0;
                            wrote     = 1'b1;
                        end
                    end
                end
                else
                begin
                    gate_next = gate_inc;
                    if (expired)
                    begin
                        tone_next = '0;
                        wrote     = 1'b1;
                    end
                end
            end
            FN_SSTOP:
            begin
                run_next  = !run_reg;
                tone_next = run_reg ? '0 : rd_note;
                wrote     = 1'b1;
            end
            FN_FWD, FN_BACK:
            begin
                // Manual stepping only counts while stopped.
                if (!run_reg)
                begin
                    step_next = (item.func == FN_FWD) ? step_fwd : step_bwd;
                    rd_idx    = step_next;
                    gate_next = '0;
                    tone_next = rd_note;
                    wrote     = 1'b1;
                end
            end
            FN_WRITE: note_we = 1'b1;
            FN_MOVE:  step_next = item.move_back ? step_bwd : step_fwd;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            bdown_reg <= 1'b0;
            run_reg   <= 1'b0;
            ticks_reg <= '0;
            gate_reg  <= '0;
            prev_reg  <= '0;
            tone_reg  <= '0;
            for (int i = 0; i < STEP_COUNT; i++)
                note_reg[i] <= '0;
        end
        else if (fire)
        begin
            step_reg  <= step_next;
            bdown_reg <= bdown_next;
            run_reg   <= run_next;
            ticks_reg <= ticks_next;
            gate_reg  <= gate_next;
            prev_reg  <= prev_next;
            tone_reg  <= tone_next;
            if (note_we)
                note_reg[step_reg] <= note_wdata;
        end
    end

    assign res.tone_value = tone_next;
    assign res.tone_write = wrote;
    assign res.step_index = step_next;
    assign res.running    = run_next;
endmodule

// File: sv/sixteen_step_note_sequencer.sv
// Top level of the sixteen-step note sequencer: stream ports, input and result registers.
// An accepted input word goes through the input register, then the result register, to the master side.
// Throughput: 1 word per cycle while the master side keeps taking result words; one pass
//   through the state update logic per word, bounded by the step-advance compare and the note table read.
// Reset (rst_n, asynchronous): note table cleared, step 0, stopped, tone silent,
//   tempo 120 bpm, loop mode, gate 10 ticks; both word registers empty.
module sixteen_step_note_sequencer
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port
    input  logic                             wr_en,
    input  logic [sxsq_pkg::WIDX_W-1:0]      wr_index,
    input  logic [sxsq_pkg::BPM_W-1:0]       wr_data,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sxsq_pkg::TDATA_IN_W-1:0]  s_tdata,   // note_value[9:0], move_back[10]
    input  logic [sxsq_pkg::FUNC_W-1:0]      s_tuser,   // func[2:0]
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sxsq_pkg::TDATA_OUT_W-1:0] m_tdata    // tone_value[6:0], tone_write[7],
                                                        // step_index[11:8], running[12]
);
    import sxsq_pkg::*;

    cfg_t    cfg;
    item_t   in_reg;
    logic    in_vld_reg;
    result_t res;
    result_t out_reg;
    logic    out_vld_reg;
    logic    out_ready;
    logic    fire;

    // The result register frees up when empty or when its word is taken this cycle.
    assign out_ready = !out_vld_reg || m_tready;
    // Process the held input word as soon as its result has somewhere to go.
    assign fire      = in_vld_reg && out_ready;
    assign s_tready  = !in_vld_reg || out_ready;

    sxsq_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    sxsq_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .cfg   (cfg),
        .item  (in_reg),
        .res   (res)
    );

    // Input register: load a new word whenever the slot is free or draining.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg.func       <= s_tuser;
            in_reg.note_value <= s_tdata[NVAL_W-1:0];
            in_reg.move_back  <= s_tdata[NVAL_W];
        end
    end

    // Result register: hold the word until the master side takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_ready)
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_reg <= res;
    end

    assign m_tvalid = out_vld_reg;
    // Fields go out lowest first: tone_value, tone_write, step_index, running.
    assign m_tdata  = TDATA_OUT_W'({out_reg.running, out_reg.step_index,
                                    out_reg.tone_write, out_reg.tone_value});
endmodule

// File: sv/sxsq_checker.sv
// Port-level checks of the sequencer's handshake timing, bound to the top level.
module sxsq_checker
(
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [sxsq_pkg::TDATA_OUT_W-1:0] m_tdata
);
    import sxsq_pkg::*;

    // Every accepted input word is followed by a valid result word on the master side.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##2 m_tvalid)
        else $error("result word missing two cycles after input accept");

    // Input side stalls only when both word registers are full and the output is blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // A result word waiting on the master side keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");
endmodule

bind sixteen_step_note_sequencer sxsq_checker u_sxsq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
